/* sv/sorted_table_binary_search_core_assert.svh */
// assertion macros for the sorted table search core
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

// clocked assertion, disabled while reset is held
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and types of the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 16;

  // item kinds carried in the input tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } stbs_entry_t;

  // table memory access from the search engine
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    stbs_entry_t       wentry;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } stbs_ram_req_t;

  // one search result
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
  } stbs_result_t;

endpackage

/* sv/sorted_table_binary_search_core.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Write item: stored into the table memory at the accept edge.
// Search item: each probe is a memory read (ST_PROBE), then a compare (ST_CMP),
// at most 11 probes over 1024 entries; a hit goes from ST_CMP and a miss from
// ST_PROBE to ST_DONE, from which the result moves into the output register.
// One item at a time; the next is taken in the cycle after ST_DONE hands off.
// Reset clears the control state and entry_count; table contents stay as is.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core import stbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: entry_count
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // slot[9:0], key[41:10], record_pos[57:42], zero
  input  logic        s_axis_tuser_i,   // action[0]
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // match_slot[9:0], match_pos[25:10], zero
  output logic        m_axis_tuser_o    // found[0]
);

  logic [CNT_W-1:0] entry_count_q;
  logic             res_valid;
  logic             res_ready;
  stbs_result_t     res;
  stbs_ram_req_t    ram_req;
  stbs_entry_t      ram_rdata;
  logic             out_valid_q;
  stbs_result_t     out_q;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  stbs_search_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_slot_i   (s_axis_tdata_i[SLOT_W-1:0]),
    .in_key_i    (s_axis_tdata_i[SLOT_W+KEY_W-1:SLOT_W]),
    .in_pos_i    (s_axis_tdata_i[SLOT_W+KEY_W+POS_W-1:SLOT_W+KEY_W]),
    .count_i     (entry_count_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  stbs_table_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register, frees the engine while a result waits
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.found;
  assign m_axis_tdata_o  = {6'b0, out_q.pos, out_q.slot};

endmodule

/* sv/stbs_table_ram.sv */
// ----------------------------------------------------------------------------
// stbs_table_ram
// Key and record position table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module stbs_table_ram import stbs_pkg::*; (
  input  logic          clk_i,
  input  stbs_ram_req_t req_i,
  output stbs_entry_t   rdata_o
);

  stbs_entry_t mem [TABLE_DEPTH];
  stbs_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wentry;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/stbs_search_fsm.sv */
// ----------------------------------------------------------------------------
// stbs_search_fsm
// Takes write and search items, loads the table and runs the binary search,
// one memory read and one compare per probe.
// ----------------------------------------------------------------------------
module stbs_search_fsm import stbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_action_i,
  input  logic [SLOT_W-1:0] in_slot_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [POS_W-1:0]  in_pos_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output stbs_result_t      res_o,
  output stbs_ram_req_t     ram_req_o,
  input  stbs_entry_t       ram_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   end_q, end_d;
  logic [CNT_W-1:0]   mid_q, mid_d;
  logic [KEY_W-1:0]   key_q, key_d;
  stbs_result_t       res_q, res_d;

  logic               accept;
  logic [CNT_W-1:0]   span;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   count_clamped;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // count above the table depth searches the whole table
  assign count_clamped = (count_i > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_i;

  // midpoint of the half-open range [lo, end), rounded down
  assign span = end_q - lo_q - CNT_W'(1);
  assign mid  = lo_q + (span >> 1);

  // table access
  always_comb begin
    ram_req_o.we     = accept && (in_action_i == ACT_WRITE) &&
                       (CNT_W'(in_slot_i) < CNT_W'(TABLE_DEPTH));
    ram_req_o.waddr  = in_slot_i[IDX_W-1:0];
    ram_req_o.wentry = '{key: in_key_i, pos: in_pos_i};
    ram_req_o.re     = (state_q == ST_PROBE) && (lo_q < end_q);
    ram_req_o.raddr  = mid[IDX_W-1:0];
  end

  // search sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    end_d   = end_q;
    mid_d   = mid_q;
    key_d   = key_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_action_i == ACT_SEARCH)) begin
          lo_d    = '0;
          end_d   = count_clamped;
          key_d   = in_key_i;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q < end_q) begin
          mid_d   = mid;
          state_d = ST_CMP;
        end else begin
          res_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        priority if ($signed(ram_rdata_i.key) == $signed(key_q)) begin
          res_d.found = 1'b1;
          res_d.slot  = SLOT_W'(mid_q);
          res_d.pos   = ram_rdata_i.pos;
          state_d     = ST_DONE;
        end else if ($signed(ram_rdata_i.key) > $signed(key_q)) begin
          end_d   = mid_q;
          state_d = ST_PROBE;
        end else begin
          lo_d    = mid_q + CNT_W'(1);
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    end_q <= end_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
  end

endmodule

/* sv/stbs_checker.sv */
// ----------------------------------------------------------------------------
// stbs_checker
// Port level checks of the sorted table binary search core.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_core_assert.svh"

module stbs_checker import stbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // a stalled result stays offered
  `STBS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")

  // a miss reports zero slot and position
  `STBS_ASSERT(a_miss_zero, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 32'b0, "miss carries nonzero data")

  // a search keeps the engine busy for the next cycle
  `STBS_ASSERT(a_search_busy, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_SEARCH) |=> !s_axis_tready_o, "engine ready right after a search item")

  // a write item never raises a result on its own
  `STBS_ASSERT(a_write_silent, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_WRITE) |=> !$rose(m_axis_tvalid_o), "result after a write item")

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
